### rtl/core/otsd_pkg.sv
`default_nettype none

package otsd_pkg;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_RADIUS = 31;
    localparam int ROW_LIMIT      = 4096;
    localparam int ROW_W          = $clog2(ROW_LIMIT);

    localparam int PIXEL_W     = 8;
    localparam int DIM_W       = 13;
    localparam int RADIUS_W    = 5;
    localparam int THRESH_W    = 8;
    localparam int POS_W       = 13;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 32;

    localparam logic [DIM_W-1:0]    RST_FRAME_WIDTH    = 13'd4096;
    localparam logic [DIM_W-1:0]    RST_FRAME_HEIGHT   = 13'd4096;
    localparam logic [RADIUS_W-1:0] RST_RADIUS_CELLS   = 5'd6;
    localparam logic [THRESH_W-1:0] RST_DARK_THRESHOLD = 8'd50;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAME_WIDTH    = 2'd0,
        CFG_FRAME_HEIGHT   = 2'd1,
        CFG_RADIUS_CELLS   = 2'd2,
        CFG_DARK_THRESHOLD = 2'd3
    } t_cfg_index;

endpackage

`default_nettype wire

### rtl/core/occupancy_threshold_square_dilation.sv
// Channel   Direction  Payload
// s_axis    in         tdata[7:0] pixel
// m_axis    out        tdata[0] occupied, [13:1] cell_row, [26:14] cell_col; tlast frame_end
// cfg       in         i_cfg_index register, i_cfg_data value; always ready
//
// One pixel per cycle unless m_axis stalls; a pixel passes stage a, then the output register.
// The rate is set by the column gap memory: one read at acceptance, one write a stage later,
// with a bypass when both hit the same column.
// Reset is synchronous; no clearing pass, a fill count marks the columns written so far.
// A stalled output holds the stage behind it; input ready falls only when both are full.
`default_nettype none

module occupancy_threshold_square_dilation
    import otsd_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]      s_axis_tdata,   // [7:0] pixel
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic [OUT_TDATA_W-1:0]          m_axis_tdata,   // [0] occupied, [13:1] cell_row,
                                                            // [26:14] cell_col, zero above
    output logic                            m_axis_tlast,   // frame_end
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0]     i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int AW      = $clog2(MAX_WIDTH);
    localparam int FW      = AW + 1;
    localparam int RW      = $clog2(MAX_RADIUS + 1);
    localparam int GAP_FAR = 2 * MAX_RADIUS + 1;
    localparam int GW      = $clog2(GAP_FAR + 1);
    localparam int PAD_W   = OUT_TDATA_W - 2 * POS_W - 1;

    function automatic logic [GW-1:0] gap_next(input logic [GW-1:0] prev);
        logic [GW-1:0] res;
        if (32'(prev) >= GAP_FAR) begin
            res = GW'(GAP_FAR);
        end else begin
            res = prev + GW'(1);
        end
        return res;
    endfunction

    logic [DIM_W-1:0]    r_frame_width;
    logic [DIM_W-1:0]    r_frame_height;
    logic [RADIUS_W-1:0] r_radius;
    logic [THRESH_W-1:0] r_threshold;

    logic [AW-1:0]    r_col_pos;
    logic [ROW_W-1:0] r_row_pos;
    logic [FW-1:0]    r_fill;
    logic [GW-1:0]    r_row_gap;
    logic [GW-1:0]    r_gap_mem [MAX_WIDTH];
    logic [GW-1:0]    r_rd;

    logic             r_a_valid;
    logic             r_a_obst;
    logic             r_a_far;
    logic             r_a_fwd;
    logic [GW-1:0]    r_a_fwd_val;
    logic [AW-1:0]    r_a_c;
    logic [ROW_W-1:0] r_a_row;
    logic             r_a_last;

    logic             r_o_valid;
    logic             r_o_occ;
    logic [POS_W-1:0] r_o_row;
    logic [POS_W-1:0] r_o_col;
    logic             r_o_last;

    logic [AW-1:0]    w_last;
    logic [ROW_W-1:0] h_last;
    logic [RW-1:0]    r_sat;
    logic [GW-1:0]    span;
    logic             acc;
    logic             a_fire;
    logic             fwd;
    logic             last_col;
    logic             last_row;
    logic [GW-1:0]    prev_v;
    logic [GW-1:0]    prev_h;
    logic [GW-1:0]    vgap;
    logic [GW-1:0]    hgap;
    logic [AW-1:0]    n_col_pos;
    logic [ROW_W-1:0] n_row_pos;

    always_comb begin
        if (r_frame_width == '0) begin
            w_last = '0;
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            w_last = AW'(MAX_WIDTH - 1);
        end else begin
            w_last = AW'(r_frame_width - DIM_W'(1));
        end
        if (r_frame_height == '0) begin
            h_last = '0;
        end else if (32'(r_frame_height) > ROW_LIMIT) begin
            h_last = ROW_W'(ROW_LIMIT - 1);
        end else begin
            h_last = ROW_W'(r_frame_height - DIM_W'(1));
        end
        if (32'(r_radius) > MAX_RADIUS) begin
            r_sat = RW'(MAX_RADIUS);
        end else begin
            r_sat = RW'(r_radius);
        end
        span = GW'({r_sat, 1'b0});
    end

    assign a_fire        = r_a_valid && (!r_o_valid || m_axis_tready);
    assign s_axis_tready = !r_a_valid || a_fire;
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign fwd           = a_fire && (r_a_c == r_col_pos);

    assign last_col = r_col_pos >= w_last;
    assign last_row = r_row_pos >= h_last;

    always_comb begin
        n_col_pos = r_col_pos;
        n_row_pos = r_row_pos;
        if (last_col) begin
            n_col_pos = '0;
            n_row_pos = last_row ? '0 : r_row_pos + ROW_W'(1);
        end else begin
            n_col_pos = r_col_pos + AW'(1);
        end
    end

    always_comb begin
        if (r_a_far) begin
            prev_v = GW'(GAP_FAR);
        end else if (r_a_fwd) begin
            prev_v = r_a_fwd_val;
        end else begin
            prev_v = r_rd;
        end
        vgap   = r_a_obst ? '0 : gap_next(prev_v);
        prev_h = (r_a_c == '0) ? GW'(GAP_FAR) : r_row_gap;
        hgap   = (vgap <= span) ? '0 : gap_next(prev_h);
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_radius       <= RST_RADIUS_CELLS;
            r_threshold    <= RST_DARK_THRESHOLD;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_FRAME_WIDTH:    r_frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT:   r_frame_height <= i_cfg_data;
                CFG_RADIUS_CELLS:   r_radius       <= i_cfg_data[RADIUS_W-1:0];
                CFG_DARK_THRESHOLD: r_threshold    <= i_cfg_data[THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_fire) begin
            r_gap_mem[r_a_c] <= vgap;
        end
        if (acc) begin
            r_rd <= r_gap_mem[r_col_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_pos <= '0;
            r_row_pos <= '0;
            r_fill    <= '0;
            r_row_gap <= GW'(GAP_FAR);
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_col_pos <= n_col_pos;
                r_row_pos <= n_row_pos;
            end
            if (a_fire) begin
                r_row_gap <= hgap;
                if ({1'b0, r_a_c} >= r_fill) begin
                    r_fill <= {1'b0, r_a_c} + FW'(1);
                end
            end
            if (acc) begin
                r_a_valid <= 1'b1;
            end else if (a_fire) begin
                r_a_valid <= 1'b0;
            end
            if (a_fire) begin
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_a_obst    <= s_axis_tdata[PIXEL_W-1:0] < r_threshold;
            r_a_far     <= (r_row_pos == '0) || (!fwd && ({1'b0, r_col_pos} >= r_fill));
            r_a_fwd     <= fwd;
            r_a_fwd_val <= vgap;
            r_a_c       <= r_col_pos;
            r_a_row     <= r_row_pos;
            r_a_last    <= last_col && last_row;
        end
        if (a_fire) begin
            r_o_occ  <= hgap <= span;
            r_o_row  <= POS_W'(r_a_row) - POS_W'(r_sat);
            r_o_col  <= POS_W'(r_a_c) - POS_W'(r_sat);
            r_o_last <= r_a_last;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_o_col, r_o_row, r_o_occ};
    assign m_axis_tlast  = r_o_last;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= MAX_WIDTH)
        else $error("fill count beyond memory depth");

    a_bypass_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && a_fire && (r_a_c == r_col_pos)) |=> r_a_fwd)
        else $error("same-column read missed the bypass");

    a_read_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !r_a_far && !r_a_fwd) |-> ({1'b0, r_a_c} < r_fill))
        else $error("column gap read from an unwritten entry");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_a_valid && r_o_valid && !m_axis_tready))
        else $error("input stalled with room in the pipeline");
`endif

endmodule

`default_nettype wire
